// File: rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// shared constants and types for the first-fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int MaxRegions = 16;
    localparam int AddrBits   = 16;
    localparam int IdxBits    = $clog2(MaxRegions);
    localparam int CntBits    = $clog2(MaxRegions + 1);
    localparam int StartBits  = AddrBits + 1;
    localparam int LenBits    = 16;
    localparam int EntryBits  = StartBits + LenBits;

    localparam logic [15:0] HeapSizeReset = 16'd19000;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOFIT    = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    localparam logic CFG_HEAP_BASE = 1'b0;
    localparam logic CFG_HEAP_SIZE = 1'b1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic [StartBits-1:0] start;
        logic [LenBits-1:0]   len;
    } t_entry;

endpackage

// File: rtl/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// sorted region table in one ram, walked by a sequencer for first-fit
// allocate and free by start address
// sequence: the table walk reads and evaluates each entry in turn (read, eval); an
//   allocate on a fit then shifts entries down to open its slot, a free on a hit shifts
//   later entries up (shift read, shift write); zero-size or full allocs go to done
// throughput: one item at a time, next item accepted the cycle after the
//   result is taken
// reset: synchronous active low, sets state idle, heap base 0, heap size 19000, clears count and output valid
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // request_size[15:0], block_address[31:16]
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // granted_address[15:0], status[18:16], zeros
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EVAL, S_SHIFT_RD, S_SHIFT_WR, S_DONE
    } t_state;

    t_state                        r_state;
    logic [15:0]                   r_heap_base;
    logic [15:0]                   r_heap_size;
    logic [ffba_pkg::CntBits-1:0]  r_count;
    logic                          r_kind;
    logic [15:0]                   r_size;
    logic [15:0]                   r_addr;
    logic [ffba_pkg::CntBits-1:0]  r_idx;
    logic [ffba_pkg::CntBits-1:0]  r_pos;
    logic [ffba_pkg::StartBits:0]  r_cand;
    logic [ffba_pkg::StartBits:0]  r_limit;
    logic [15:0]                   r_grant;
    ffba_pkg::t_status             r_status;
    logic                          r_out_valid;

    logic                          we;
    logic [ffba_pkg::IdxBits-1:0]  waddr;
    logic [ffba_pkg::IdxBits-1:0]  raddr;
    ffba_pkg::t_entry              wdata;
    ffba_pkg::t_entry              rdata;
    logic [ffba_pkg::StartBits:0]  bound;
    logic [ffba_pkg::StartBits:0]  cand_end;
    logic [ffba_pkg::StartBits:0]  heap_end;
    logic                          at_end;

    ffba_ram #(
        .Width (ffba_pkg::EntryBits),
        .Depth (ffba_pkg::MaxRegions)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_status, r_grant};

    assign heap_end = {2'd0, r_heap_base} + {2'd0, r_heap_size};
    assign at_end   = (r_idx == r_count);
    always_comb begin
        bound = at_end ? r_limit : {1'b0, rdata.start};
        if (bound > r_limit) begin
            bound = r_limit;
        end
    end
    assign cand_end = r_cand + {2'd0, r_size};

    // alloc shifts down from count toward pos, free shifts up from pos
    always_comb begin
        we    = 1'b0;
        waddr = r_idx[ffba_pkg::IdxBits-1:0];
        wdata = rdata;
        raddr = r_idx[ffba_pkg::IdxBits-1:0];
        if (r_state == S_SHIFT_RD) begin
            if (r_kind == ffba_pkg::KIND_ALLOC) begin
                raddr = ffba_pkg::IdxBits'(r_idx - 1'b1);
            end else begin
                raddr = ffba_pkg::IdxBits'(r_idx + 1'b1);
            end
        end
        if (r_state == S_SHIFT_WR) begin
            we = 1'b1;
            if (r_kind == ffba_pkg::KIND_ALLOC && r_idx == r_pos) begin
                wdata.start = r_cand[ffba_pkg::StartBits-1:0];
                wdata.len   = r_size;
            end else begin
                wdata = rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_heap_base <= '0;
            r_heap_size <= ffba_pkg::HeapSizeReset;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ffba_pkg::CFG_HEAP_BASE: r_heap_base <= i_cfg_wdata;
                    ffba_pkg::CFG_HEAP_SIZE: r_heap_size <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_kind  <= s_axis_tuser;
                        r_size  <= s_axis_tdata[15:0];
                        r_addr  <= s_axis_tdata[31:16];
                        r_idx   <= '0;
                        r_grant <= '0;
                        r_cand  <= {2'd0, r_heap_base};
                        r_limit <= (heap_end > (ffba_pkg::StartBits+1)'(1 << ffba_pkg::AddrBits)) ?
                                   (ffba_pkg::StartBits+1)'(1 << ffba_pkg::AddrBits) : heap_end;
                        if (s_axis_tuser == ffba_pkg::KIND_ALLOC && s_axis_tdata[15:0] == 16'd0)
                        begin
                            r_status <= ffba_pkg::ST_ZERO;
                            r_state  <= S_DONE;
                        end else if (s_axis_tuser == ffba_pkg::KIND_ALLOC &&
                                     r_count == ffba_pkg::CntBits'(ffba_pkg::MaxRegions)) begin
                            r_status <= ffba_pkg::ST_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (r_kind == ffba_pkg::KIND_ALLOC) begin
                        if (cand_end <= bound) begin
                            r_pos    <= r_idx;
                            r_grant  <= r_cand[15:0];
                            r_status <= ffba_pkg::ST_OK;
                            r_idx    <= r_count;
                            r_count  <= r_count + 1'b1;
                            r_state  <= S_SHIFT_RD;
                        end else if (at_end) begin
                            r_status <= ffba_pkg::ST_NOFIT;
                            r_state  <= S_DONE;
                        end else begin
                            r_cand  <= {1'b0, rdata.start} + {2'd0, rdata.len};
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_READ;
                        end
                    end else begin
                        if (at_end) begin
                            r_status <= ffba_pkg::ST_NOTFOUND;
                            r_state  <= S_DONE;
                        end else if (rdata.start == {1'b0, r_addr}) begin
                            r_status <= ffba_pkg::ST_OK;
                            r_count  <= r_count - 1'b1;
                            if (r_idx + 1'b1 == r_count) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_SHIFT_RD;
                            end
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_SHIFT_RD: begin
                    r_state <= S_SHIFT_WR;
                end
                S_SHIFT_WR: begin
                    if (r_kind == ffba_pkg::KIND_ALLOC) begin
                        if (r_idx == r_pos) begin
                            r_state <= S_DONE;
                        end else begin
                            r_idx   <= r_idx - 1'b1;
                            r_state <= S_SHIFT_RD;
                        end
                    end else begin
                        if (r_idx + 1'b1 == r_count) begin
                            r_state <= S_DONE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_SHIFT_RD;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ffba_pkg::CntBits'(ffba_pkg::MaxRegions);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("region count overflow");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_status != ffba_pkg::ST_OK) |-> (r_grant == 16'd0))
        else $error("grant on failure");

    a_out_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE)) else $error("stray output");

endmodule
